// ----- design/tsf_pkg.sv -----
// Shared types, character codes and digit helpers of the telemetry sentence formatter.
package tsf_pkg;

  // Sentence geometry.
  localparam int SAMPLE_COUNT   = 5;
  localparam int SENTENCE_LEN   = 37;
  localparam int POS_W          = 6;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SENTENCE_LEN - 1);
  localparam int TSF_FIFO_DEPTH = 2;

  // ASCII codes used by the sentence.
  localparam logic [6:0] CH_DOLLAR = 7'h24;
  localparam logic [6:0] CH_B      = 7'h42;
  localparam logic [6:0] CH_E      = 7'h45;
  localparam logic [6:0] CH_A      = 7'h41;
  localparam logic [6:0] CH_C      = 7'h43;
  localparam logic [6:0] CH_O      = 7'h4F;
  localparam logic [6:0] CH_N      = 7'h4E;
  localparam logic [6:0] CH_TWO    = 7'h32;
  localparam logic [6:0] CH_ONE    = 7'h31;
  localparam logic [6:0] CH_DASH   = 7'h2D;
  localparam logic [6:0] CH_COMMA  = 7'h2C;
  localparam logic [6:0] CH_S      = 7'h53;
  localparam logic [6:0] CH_P      = 7'h50;
  localparam logic [6:0] CH_STAR   = 7'h2A;
  localparam logic [6:0] CH_ZERO   = 7'h30;

  // Fixed part of the checksum: header text, group digit, comma, 'S' and 'P',
  // plus the leading '$' for group two.
  localparam logic [11:0] CHECK_BASE_G0 = 12'd775;
  localparam logic [11:0] CHECK_BASE_G1 = 12'd812;

  // What a sentence position shows.
  typedef enum logic [1:0] {
    CK_LIT,
    CK_GROUP,
    CK_DIGIT
  } char_kind_t;

  // Which number a digit position is taken from.
  typedef enum logic [2:0] {
    SRC_A,
    SRC_B,
    SRC_C,
    SRC_D,
    SRC_E,
    SRC_SUM,
    SRC_CHECK
  } digit_src_t;

  // Decoded plan for one sentence position.
  typedef struct packed {
    char_kind_t kind;
    logic [6:0] lit;
    digit_src_t src;
    logic       first;  // most significant digit of its number
    logic [1:0] pw;     // decimal place: 0 units .. 3 thousands
  } pos_plan_t;

  // One classified frame waiting in the queue.
  typedef struct packed {
    logic                              group;
    logic [SAMPLE_COUNT-1:0][7:0]      samples;
    logic [10:0]                       sum;
    logic [11:0]                       check;
  } tsf_entry_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } tsf_q_status_t;

  function automatic logic [9:0] pow_of(logic [1:0] pw);
    logic [9:0] p;
    case (pw)
      2'd0:    p = 10'd1;
      2'd1:    p = 10'd10;
      2'd2:    p = 10'd100;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

  // Leading decimal digit of a value known to be below ten times the place.
  function automatic logic [3:0] digit_of(logic [11:0] work, logic [1:0] pw);
    logic [9:0]  p;
    logic [3:0]  d;
    logic [13:0] thr;
    p = pow_of(pw);
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      thr = 14'(k) * 14'(p);
      if ({2'b00, work} >= thr) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

  function automatic pos_plan_t lit_plan(logic [6:0] ch);
    pos_plan_t pl;
    pl = '{kind: CK_LIT, lit: ch, src: SRC_A, first: 1'b0, pw: 2'd0};
    return pl;
  endfunction

  function automatic pos_plan_t dig_plan(digit_src_t src, logic first, logic [1:0] pw);
    pos_plan_t pl;
    pl = '{kind: CK_DIGIT, lit: CH_ZERO, src: src, first: first, pw: pw};
    return pl;
  endfunction

  // Layout of the sentence, position by position.
  function automatic pos_plan_t char_plan(logic [POS_W-1:0] pos);
    pos_plan_t pl;
    case (pos)
      6'd0:  pl = lit_plan(CH_DOLLAR);
      6'd1:  pl = lit_plan(CH_B);
      6'd2:  pl = lit_plan(CH_E);
      6'd3:  pl = lit_plan(CH_A);
      6'd4:  pl = lit_plan(CH_C);
      6'd5:  pl = lit_plan(CH_O);
      6'd6:  pl = lit_plan(CH_N);
      6'd7:  pl = lit_plan(CH_TWO);
      6'd8:  pl = lit_plan(CH_DASH);
      6'd9:  pl = '{kind: CK_GROUP, lit: CH_ONE, src: SRC_A, first: 1'b0, pw: 2'd0};
      6'd10: pl = lit_plan(CH_COMMA);
      6'd11: pl = dig_plan(SRC_A, 1'b1, 2'd2);
      6'd12: pl = dig_plan(SRC_A, 1'b0, 2'd1);
      6'd13: pl = dig_plan(SRC_A, 1'b0, 2'd0);
      6'd14: pl = dig_plan(SRC_B, 1'b1, 2'd2);
      6'd15: pl = dig_plan(SRC_B, 1'b0, 2'd1);
      6'd16: pl = dig_plan(SRC_B, 1'b0, 2'd0);
      6'd17: pl = dig_plan(SRC_C, 1'b1, 2'd2);
      6'd18: pl = dig_plan(SRC_C, 1'b0, 2'd1);
      6'd19: pl = dig_plan(SRC_C, 1'b0, 2'd0);
      6'd20: pl = dig_plan(SRC_D, 1'b1, 2'd2);
      6'd21: pl = dig_plan(SRC_D, 1'b0, 2'd1);
      6'd22: pl = dig_plan(SRC_D, 1'b0, 2'd0);
      6'd23: pl = dig_plan(SRC_E, 1'b1, 2'd2);
      6'd24: pl = dig_plan(SRC_E, 1'b0, 2'd1);
      6'd25: pl = dig_plan(SRC_E, 1'b0, 2'd0);
      6'd26: pl = lit_plan(CH_S);
      6'd27: pl = dig_plan(SRC_SUM, 1'b1, 2'd3);
      6'd28: pl = dig_plan(SRC_SUM, 1'b0, 2'd2);
      6'd29: pl = dig_plan(SRC_SUM, 1'b0, 2'd1);
      6'd30: pl = dig_plan(SRC_SUM, 1'b0, 2'd0);
      6'd31: pl = lit_plan(CH_P);
      6'd32: pl = dig_plan(SRC_CHECK, 1'b1, 2'd3);
      6'd33: pl = dig_plan(SRC_CHECK, 1'b0, 2'd2);
      6'd34: pl = dig_plan(SRC_CHECK, 1'b0, 2'd1);
      6'd35: pl = dig_plan(SRC_CHECK, 1'b0, 2'd0);
      default: pl = lit_plan(CH_STAR);
    endcase
    return pl;
  endfunction

endpackage

// ----- design/tsf_front.sv -----
// Front part: takes frames in, sums the samples and forms the checksum.
module tsf_front
  import tsf_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [SAMPLE_COUNT-1:0][7:0] in_samples,
  input  logic                         in_group,
  input  tsf_q_status_t                q_st,
  output logic                         push,
  output tsf_entry_t                   push_entry
);

  logic                         valid_r, valid_nxt;
  logic                         group_r;
  logic [SAMPLE_COUNT-1:0][7:0] samples_r;
  logic [10:0]                  sum_r, sum_nxt;
  logic                         take;

  // The stage moves on when the queue has room.
  assign push      = valid_r && !q_st.full;
  assign in_tready = !valid_r || push;
  assign take      = in_tvalid && in_tready;

  // Sample total for the incoming frame.
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < SAMPLE_COUNT; k++) begin
      sum_nxt = sum_nxt + 11'(in_samples[k]);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      group_r   <= in_group;
      samples_r <= in_samples;
      sum_r     <= sum_nxt;
    end
  end

  // The checksum holds the samples once and the total once, so twice the total.
  always_comb begin
    push_entry.group   = group_r;
    push_entry.samples = samples_r;
    push_entry.sum     = sum_r;
    push_entry.check   = {sum_r, 1'b0} + (group_r ? CHECK_BASE_G1 : CHECK_BASE_G0);
  end

endmodule

// ----- design/tsf_fifo.sv -----
// Short queue of classified frames between the front and back parts.
module tsf_fifo
  import tsf_pkg::*;
#(
  parameter int DEPTH = TSF_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tsf_entry_t    push_entry,
  input  logic          pop,
  output tsf_entry_t    head,
  output tsf_q_status_t q_st
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tsf_entry_t         store_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign head       = store_r[rd_ptr_r];
  assign q_st.empty = (count_r == '0);
  assign q_st.full  = (count_r == CNT_FULL);

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_END) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_END) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- design/tsf_back.sv -----
// Back part: walks the sentence from the queue head, one character a cycle unless stalled.
module tsf_back
  import tsf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tsf_entry_t    head,
  input  tsf_q_status_t q_st,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [6:0]    out_char,
  output logic          out_last
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [11:0]      rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_char_r;
  logic             out_last_r;

  pos_plan_t        plan;
  logic [11:0]      field_val;
  logic [11:0]      work;
  logic [3:0]       dig;
  logic [6:0]       ch;
  logic             gen;
  logic             at_last;

  assign plan    = char_plan(pos_r);
  assign at_last = (pos_r == POS_LAST);
  assign gen     = !q_st.empty && (!out_valid_r || out_tready);
  assign pop     = gen && at_last;

  // Number the current digit position is cut from.
  always_comb begin
    case (plan.src)
      SRC_A:     field_val = 12'(head.samples[0]);
      SRC_B:     field_val = 12'(head.samples[1]);
      SRC_C:     field_val = 12'(head.samples[2]);
      SRC_D:     field_val = 12'(head.samples[3]);
      SRC_E:     field_val = 12'(head.samples[4]);
      SRC_SUM:   field_val = 12'(head.sum);
      SRC_CHECK: field_val = head.check;
      default:   field_val = '0;
    endcase
  end

  // One decimal digit a cycle while characters are generated; the remainder carries to the next place.
  always_comb begin
    work    = plan.first ? field_val : rem_r;
    dig     = digit_of(work, plan.pw);
    rem_nxt = work - 12'(14'(dig) * 14'(pow_of(plan.pw)));
  end

  // Character for the current position.
  always_comb begin
    case (plan.kind)
      CK_LIT:   ch = plan.lit;
      CK_GROUP: ch = head.group ? CH_TWO : CH_ONE;
      CK_DIGIT: ch = CH_ZERO + 7'(dig);
      default:  ch = plan.lit;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (gen) begin
      pos_nxt       = at_last ? '0 : pos_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register and digit remainder.
  always_ff @(posedge clk) begin
    if (gen) begin
      out_char_r <= ch;
      out_last_r <= at_last;
      rem_r      <= rem_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;

endmodule

// ----- design/telemetry_sentence_formatter_core.sv -----
// Top level of the telemetry sentence formatter.
//
//  Channel  | Direction | tdata                               | tuser       | tlast
//  ---------+-----------+-------------------------------------+-------------+-----------
//  in_      | slave     | sample_a..sample_e, 8 bits each     | frame_group | -
//  out_     | master    | out_char (7 bits), one zero bit     | -           | last_char
//
// Each frame yields 37 output transactions, one a cycle when the output never stalls,
// and the character sequencer in the back part sets that figure; a frame leaves the
// queue only after its last character is formed. An accepted frame passes through the
// front register and the queue to the output register. Reset is synchronous and clears
// the queue, the sequencer and the output valid flag. A stalled output holds its
// transaction and the queue lets the input go on taking frames until it fills.
module telemetry_sentence_formatter_core
  import tsf_pkg::*;
#(
  parameter int FIFO_DEPTH = TSF_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // sample_a [7:0], sample_b, sample_c, sample_d, sample_e
  input  logic        in_tuser,   // frame_group
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_char [6:0], zero pad [7]
  output logic        out_tlast
);

  tsf_q_status_t q_st;
  tsf_entry_t    push_entry;
  tsf_entry_t    head;
  logic          push;
  logic          pop;
  logic [6:0]    out_char;

  tsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_samples (in_tdata),
    .in_group   (in_tuser),
    .q_st       (q_st),
    .push       (push),
    .push_entry (push_entry)
  );

  tsf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_st       (q_st)
  );

  tsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_st       (q_st),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

// ----- design/tsf_checker.sv -----
// Port-level checks of the sentence formatter, bound to its top level.
module tsf_checker
  import tsf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  logic after_last_r, after_last_nxt;

  // Set when the next output transaction opens a new sentence.
  always_comb begin
    after_last_nxt = after_last_r;
    if (out_tvalid && out_tready) begin
      after_last_nxt = out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_last_r <= 1'b1;
    end else begin
      after_last_r <= after_last_nxt;
    end
  end

  // A waiting input transaction is offered unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input transaction changed while waiting");

  // A stalled output transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // Every sentence opens with the dollar sign.
  a_sentence_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && after_last_r |-> out_tdata[6:0] == CH_DOLLAR && !out_tlast)
    else $error("sentence does not open with the dollar sign");

  // The closing character is always the star.
  a_sentence_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[6:0] == CH_STAR)
    else $error("last character of a sentence is not the star");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind telemetry_sentence_formatter_core tsf_checker u_tsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
